// ===== design/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// Min/max stack package
// Shared types and constants for the min/max stack: command codes, the
// transaction structs on the ports and the per-level state of a stack cell.
// ----------------------------------------------------------------------------
package mms_pkg;

  // Number of stack levels, one cell per level
  localparam int unsigned STACK_DEPTH = 64;
  // Fill count holds 0 to STACK_DEPTH inclusive
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_MAX  = 2'd2,
    KIND_MIN  = 2'd3
  } kind_e;

  // Command transaction
  typedef struct packed {
    kind_e                     kind;
    logic signed [DATA_W-1:0]  push_value;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0]  answer_value;
    logic                      answer_is_min;
  } result_t;

  // Contents of one stack level: the entry and the running max/min of it
  // and every level below it
  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  level_max;
    logic signed [DATA_W-1:0]  level_min;
  } level_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;  // every level moves one place deeper
    logic pop;   // every level moves one place toward the top
  } shift_ctl_t;

endpackage

// ===== design/mms_cell.sv =====
// ----------------------------------------------------------------------------
// Min/max stack cell
// Holds one stack level. On a push it takes the level from its upper
// neighbor, on a pop the level from its lower neighbor, else it holds.
// ----------------------------------------------------------------------------
module mms_cell
  import mms_pkg::*;
(
  input  logic       clk_i,
  input  shift_ctl_t ctl_i,
  input  level_t     above_i,
  input  level_t     below_i,
  output level_t     level_o
);

  level_t level_q, level_d;

  // Next level: shift in from a neighbor or hold
  always_comb begin
    level_d = level_q;
    if (ctl_i.push) begin
      level_d = above_i;
    end else if (ctl_i.pop) begin
      level_d = below_i;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign level_o = level_q;

endmodule

// ===== design/min_max_stack.sv =====
// A query result is registered and appears in the cycle after its command is accepted.
// Throughput: one command per cycle; every command is a single shift of the
// cell chain plus a compare on the top cell, so busy never rises.
// Reset clears the fill count (stack empty) and the result strobe; cell
// contents are not cleared and are never read before a push writes them.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Min/max stack top level
// Bounded stack of signed values built as a chain of shifting cells, with a
// running max and min kept per level so queries read only the top cell.
// ----------------------------------------------------------------------------
module min_max_stack
  import mms_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    result_valid_o,
  output result_t result_o
);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic             result_valid_q, result_valid_d;
  result_t          result_q, result_d;

  logic       accept;
  logic       empty;
  logic       full;
  shift_ctl_t ctl;
  level_t     new_level;
  level_t     levels [STACK_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (fill_q == '0);
  assign full   = (fill_q == CNT_W'(STACK_DEPTH));

  // Shift control: push drops when full, pop ignored when empty
  always_comb begin
    ctl.push = accept && (cmd_i.kind == KIND_PUSH) && !full;
    ctl.pop  = accept && (cmd_i.kind == KIND_POP) && !empty;
  end

  // New top level: running max/min against the current top
  always_comb begin
    new_level.value = cmd_i.push_value;
    if (empty) begin
      new_level.level_max = cmd_i.push_value;
      new_level.level_min = cmd_i.push_value;
    end else begin
      new_level.level_max = (cmd_i.push_value > levels[0].level_max) ?
                            cmd_i.push_value : levels[0].level_max;
      new_level.level_min = (cmd_i.push_value < levels[0].level_min) ?
                            cmd_i.push_value : levels[0].level_min;
    end
  end

  // Cell chain, level 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    level_t above;
    level_t below;

    if (i == 0) begin : g_top
      assign above = new_level;
    end else begin : g_mid
      assign above = levels[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_inner
      assign below = levels[i+1];
    end

    mms_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .level_o (levels[i])
    );
  end

  // Fill count and query result
  always_comb begin
    fill_d         = fill_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    if (ctl.push) begin
      fill_d = fill_q + 1'b1;
    end else if (ctl.pop) begin
      fill_d = fill_q - 1'b1;
    end
    if (accept && !empty) begin
      case (cmd_i.kind)
        KIND_MAX: begin
          result_valid_d         = 1'b1;
          result_d.answer_value  = levels[0].level_max;
          result_d.answer_is_min = 1'b0;
        end
        KIND_MIN: begin
          result_valid_d         = 1'b1;
          result_d.answer_value  = levels[0].level_min;
          result_d.answer_is_min = 1'b1;
        end
        default: begin
          result_valid_d = 1'b0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      fill_q         <= fill_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Fill count never passes the stack depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  // A result only follows a query on a non-empty stack
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(accept && !empty &&
      (cmd_i.kind == KIND_MAX || cmd_i.kind == KIND_MIN)))
    else $error("result without a matching query");

  // An accepted push on a non-full stack grows it by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.kind == KIND_PUSH && !full) |=>
      fill_q == $past(fill_q) + 1'b1)
    else $error("push did not grow the stack");

  // Top level keeps max at or above min after a push
  a_top_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |=> levels[0].level_max >= levels[0].level_min)
    else $error("top level max below min");

  // Pop on an empty stack leaves it empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.kind == KIND_POP && empty) |=> fill_q == '0)
    else $error("pop on empty stack changed the fill count");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Min/max stack testbench
// Drives push, pop and max/min query commands into the stack, checks every
// query answer against a behavioral copy of the stack, and ends with a
// single pass or fail line.
// ----------------------------------------------------------------------------
module testbench;
  import mms_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS    = 105;
  localparam int unsigned PHASE_COUNT    = 12;

  // Behavioral stack: per-level running max/min and the answers still due
  class stack_answer_checker;
    logic signed [DATA_W-1:0] entry_vals [STACK_DEPTH];
    logic signed [DATA_W-1:0] run_max [STACK_DEPTH];
    logic signed [DATA_W-1:0] run_min [STACK_DEPTH];
    int unsigned              depth_used;
    result_t                  answers_due [$];
    int unsigned              error_count;

    function new();
      depth_used  = 0;
      error_count = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    // Apply one accepted command transaction to the model stack
    function void take_command(cmd_t c);
      result_t ans;
      int unsigned top;
      case (c.kind)
        KIND_PUSH: begin
          if (depth_used < STACK_DEPTH) begin
            top = depth_used;
            entry_vals[top] = c.push_value;
            if (top == 0) begin
              run_max[top] = c.push_value;
              run_min[top] = c.push_value;
            end else begin
              run_max[top] = (c.push_value > run_max[top-1]) ? c.push_value : run_max[top-1];
              run_min[top] = (c.push_value < run_min[top-1]) ? c.push_value : run_min[top-1];
            end
            depth_used = top + 1;
          end
        end
        KIND_POP: begin
          if (depth_used > 0) depth_used--;
        end
        default: begin
          // queries on an empty stack produce nothing
          if (depth_used > 0) begin
            top = depth_used - 1;
            ans.answer_is_min = (c.kind == KIND_MIN);
            ans.answer_value  = ans.answer_is_min ? run_min[top] : run_max[top];
            answers_due.push_back(ans);
          end
        end
      endcase
    endfunction

    // Compare one result transaction with the oldest answer due
    task check_answer(result_t r);
      result_t due;
      if (answers_due.size() == 0) begin
        report($sformatf("unexpected result value=%0d is_min=%0b",
                         r.answer_value, r.answer_is_min));
      end else begin
        due = answers_due.pop_front();
        if (r.answer_value !== due.answer_value)
          report($sformatf("answer_value got %0d want %0d",
                           r.answer_value, due.answer_value));
        if (r.answer_is_min !== due.answer_is_min)
          report($sformatf("answer_is_min got %0b want %0b",
                           r.answer_is_min, due.answer_is_min));
      end
    endtask

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd_i;
  logic    result_valid_o;
  result_t result_o;

  stack_answer_checker stack_chk = new();
  int unsigned         quiet_cycles;

  min_max_stack u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Monitor: answers first, then the command accepted at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) stack_chk.check_answer(result_o);
      if (start && !busy) stack_chk.take_command(cmd_i);
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic cmd_t make_cmd(kind_e k, logic [DATA_W-1:0] v);
    cmd_t c;
    c.kind       = k;
    c.push_value = v;
    return c;
  endfunction

  // Push values lean on the extremes and on small numbers for ties
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return make_cmd(KIND_PUSH, pick_value());
    if (r < push_pct + pop_pct) return make_cmd(KIND_POP, $urandom);
    return make_cmd($urandom_range(0, 1) ? KIND_MAX : KIND_MIN, $urandom);
  endfunction

  // Present one command and hold it until the handshake completes
  task send_cmd(input cmd_t c);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Sender gap with start low for a length set by n, with junk on the command bus
  task hold_off(input int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    cmd_i <= rand_cmd(25, 25);
    repeat (n - 1) @(negedge clk_i);
  endtask

  task drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (stack_chk.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    cmd_t        dir_cmds [$];
    int unsigned push_pct;
    int unsigned pop_pct;
    bit          gaps_on;

    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = '0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-stack cases, extremes, ignored push_value
    dir_cmds = '{
      make_cmd(KIND_MAX, 32'h0), make_cmd(KIND_MIN, 32'h0), make_cmd(KIND_POP, 32'h0),
      make_cmd(KIND_PUSH, 32'h7FFF_FFFF), make_cmd(KIND_MAX, 32'h0),
      make_cmd(KIND_MIN, 32'h0), make_cmd(KIND_PUSH, 32'h8000_0000),
      make_cmd(KIND_MAX, 32'h0), make_cmd(KIND_MIN, 32'h0),
      make_cmd(KIND_PUSH, 32'h0), make_cmd(KIND_PUSH, 32'hFFFF_FFFF),
      make_cmd(KIND_MIN, 32'h0), make_cmd(KIND_MAX, 32'h0),
      make_cmd(KIND_POP, 32'h0), make_cmd(KIND_POP, 32'h0), make_cmd(KIND_MIN, 32'h0),
      make_cmd(KIND_POP, 32'h0), make_cmd(KIND_POP, 32'h0), make_cmd(KIND_POP, 32'h0),
      make_cmd(KIND_MAX, 32'h0), make_cmd(KIND_PUSH, 32'h5),
      make_cmd(KIND_POP, 32'hFFFF_FFFF), make_cmd(KIND_MIN, 32'hFFFF_FFFF),
      make_cmd(KIND_PUSH, 32'hFFFF_FFF9), make_cmd(KIND_MAX, 32'hFFFF_FFFF)
    };
    foreach (dir_cmds[i]) send_cmd(dir_cmds[i]);
    drain();

    // Random phases: grow to full, shrink to empty, mixed; last has no gaps
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 6)
        0, 1:    begin push_pct = 70; pop_pct = 10; end
        2, 5:    begin push_pct = 35; pop_pct = 35; end
        default: begin push_pct = 10; pop_pct = 70; end
      endcase
      gaps_on = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (gaps_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 18));
        send_cmd(rand_cmd(push_pct, pop_pct));
      end
      if (p % 3 == 2) drain();
    end

    // Wait out the last answers, then wait on for any stray strobes
    drain();
    repeat (4) @(posedge clk_i);
    if (stack_chk.error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
